// File: sv/lise_pkg.sv
// ----------------------------------------------------------------------------
// lise_pkg: shared types and constants of the load-immediate sequence expander
// Holds the instruction kinds, the sequencer phases and the job descriptor that
// travels from the classifying front through the queue to the back sequencer.
// ----------------------------------------------------------------------------
package lise_pkg;

  // Port and field widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned REG_W      = 5;
  localparam int unsigned IMM_W      = 21;

  // Job queue depth (power of two, pointers wrap by truncation)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Hard-wired zero register
  localparam logic [REG_W-1:0] REG_X0 = '0;

  // Emitted instruction kinds
  typedef enum logic [2:0] {
    OP_LUI  = 3'd0,
    OP_ADDI = 3'd1,
    OP_ORI  = 3'd2,
    OP_SLLI = 3'd3,
    OP_SRLI = 3'd4,
    OP_ADD  = 3'd5
  } op_t;

  // Sequencer phases, in emission order
  localparam int unsigned PH_N = 10;
  localparam int unsigned PH_W = 4;

  typedef enum logic [PH_W-1:0] {
    PH_G1_LUI = 4'd0,  // lui of the first group
    PH_G1_OP2 = 4'd1,  // addi/ori of the first group
    PH_ZX_SLL = 4'd2,  // zero-extend lower half: shift up
    PH_ZX_SRL = 4'd3,  // zero-extend lower half: shift down
    PH_G2_LUI = 4'd4,  // lui of the upper half
    PH_G2_OP2 = 4'd5,  // addi/ori of the upper half
    PH_SLL32  = 4'd6,  // move upper half into place
    PH_ADD    = 4'd7,  // combine halves
    PH_CH_SLL = 4'd8,  // chunk path: shift
    PH_CH_ORI = 4'd9   // chunk path: or in chunk
  } ph_t;

  // Job descriptor produced by the front
  typedef struct packed {
    logic [REG_W-1:0]        rd;
    logic [REG_W-1:0]        r2;
    logic                    g1_lui;
    logic signed [IMM_W-1:0] g1_lui_imm;
    logic                    g1_op2;
    op_t                     g1_op2_kind;
    logic [REG_W-1:0]        g1_op2_rs1;
    logic signed [IMM_W-1:0] g1_op2_imm;
    logic                    zext;
    logic                    g2_lui;
    logic signed [IMM_W-1:0] g2_lui_imm;
    logic                    g2_op2;
    op_t                     g2_op2_kind;
    logic [REG_W-1:0]        g2_op2_rs1;
    logic signed [IMM_W-1:0] g2_op2_imm;
    logic                    sll;
    logic                    add;
    logic                    chunk;
    logic [31:0]             low;
  } job_t;

endpackage

// File: sv/lise_front.sv
// ----------------------------------------------------------------------------
// lise_front: input side of the expander
// Accepts one immediate per transfer, picks the load path and works out every
// fixed instruction of the sequence, then hands a job descriptor to the queue.
// ----------------------------------------------------------------------------
module lise_front
  import lise_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // immediate[63:0], dest_reg[68:64], scratch_reg[73:69]
  input  logic [IN_USER_W-1:0] s_tuser,   // scratch_free[0]
  output logic                 push_valid,
  input  logic                 push_ready,
  output job_t                 push_job
);

  logic [VAL_W-1:0] value;
  logic [REG_W-1:0] rd;
  logic [REG_W-1:0] sreg;
  logic             sfree;
  logic [VAL_W-1:0] t;
  logic             fits;
  logic [31:0]      up;
  logic [31:0]      low;
  logic             up_zero;
  logic             low_zero;
  logic             short_hi_nz;
  logic             low_hi_nz;
  logic             sim_neg;
  logic             no_temp;
  logic             up_nz;
  logic [33:0]      sum_a;
  logic [33:0]      sum_b;
  logic [33:0]      sum_u;
  logic [11:0]      lo_u;
  logic [REG_W-1:0] r2;
  job_t             job;

  // Pass transfers straight into the queue
  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign push_job   = job;

  // Field split and the shared adders
  always_comb begin
    value = s_tdata[63:0];
    rd    = s_tdata[68:64];
    sreg  = s_tdata[73:69];
    sfree = s_tuser[0];
    t     = value + 64'h800;
    fits  = (t[63:31] == '0) || (t[63:31] == '1);
    up    = value[63:32];
    low   = value[31:0];
    up_zero  = (up == '0);
    low_zero = (low == '0);
    short_hi_nz = |t[31:12];
    low_hi_nz   = |low[31:11];
    // Sign of the rebuilt lower half after lui/addi
    sim_neg = t[31] | ((t[31:12] == '0) & value[11]);
    no_temp = !up_zero && !low_zero && !sfree;
    // Upper half as is, or plus one to compensate a negative lower half
    sum_a = {{2{up[31]}}, up} + 34'h800;
    sum_b = {2'b00, up} + 34'h801;
  end

  // Classify and fill the job descriptor
  always_comb begin
    job   = '0;
    up_nz = 1'b0;
    sum_u = sum_a;
    lo_u  = '0;
    r2    = rd;
    job.rd  = rd;
    job.low = low;
    if (fits) begin
      // Value fits in 32 bits after rounding
      job.g1_lui      = short_hi_nz;
      job.g1_lui_imm  = {t[31], t[31:12]};
      job.g1_op2      = !short_hi_nz || (|value[11:0]);
      job.g1_op2_kind = OP_ADDI;
      job.g1_op2_rs1  = short_hi_nz ? rd : REG_X0;
      job.g1_op2_imm  = {{(IMM_W-12){value[11]}}, value[11:0]};
    end else begin
      if (no_temp) begin
        // Upper half in dest_reg, lower half shifted in by chunks
        up_nz     = 1'b1;
        sum_u     = sum_a;
        r2        = rd;
        job.chunk = 1'b1;
      end else begin
        // Lower half first, into dest_reg
        if (!low_zero) begin
          job.g1_lui      = low_hi_nz;
          job.g1_lui_imm  = {1'b0, t[31:12]};
          job.g1_op2      = !low_hi_nz || (|value[11:0]);
          job.g1_op2_kind = low_hi_nz ? OP_ADDI : OP_ORI;
          job.g1_op2_rs1  = low_hi_nz ? rd : REG_X0;
          job.g1_op2_imm  = {{(IMM_W-12){1'b0}}, value[11:0]};
        end
        job.zext = sim_neg & up_zero;
        sum_u    = sim_neg ? sum_b : sum_a;
        up_nz    = sim_neg ? (up != '1) : !up_zero;
        up_nz    = up_nz && !job.zext;
        r2       = low_zero ? rd : sreg;
        job.sll  = up_nz;
        job.add  = up_nz && !low_zero;
      end
      // Upper half build
      lo_u            = sum_u[11:0] ^ 12'h800;
      job.r2          = r2;
      job.g2_lui      = up_nz && (|sum_u[33:12]);
      job.g2_lui_imm  = {1'b0, sum_u[31:12]};
      job.g2_op2      = up_nz && (!(|sum_u[33:12]) || (|lo_u));
      job.g2_op2_kind = (|sum_u[33:12]) ? OP_ADDI : OP_ORI;
      job.g2_op2_rs1  = (|sum_u[33:12]) ? r2 : REG_X0;
      job.g2_op2_imm  = {{(IMM_W-12){1'b0}}, lo_u};
    end
  end

endmodule

// File: sv/lise_queue.sv
// ----------------------------------------------------------------------------
// lise_queue: short job queue
// Two-entry first-in first-out store between front and back so either side
// can stall on its own.
// ----------------------------------------------------------------------------
module lise_queue
  import lise_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

endmodule

// File: sv/lise_back.sv
// ----------------------------------------------------------------------------
// lise_back: instruction sequencer
// Walks the enabled phases of the job at the queue head, one instruction per
// cycle while the output register can take it, runs the chunk search of the
// no-scratch path and drives the output register.
// ----------------------------------------------------------------------------
module lise_back
  import lise_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  job_t                  job,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // rd_out[4:0], rs1_out[9:5], rs2_out[14:10], imm_out[35:15]
  output logic [OUT_USER_W-1:0] m_tuser,   // op_kind[2:0]
  output logic                  m_tlast    // last
);

  // Count leading zeros of a 32-bit word, 32 when it is zero
  function automatic logic [5:0] lead_zeros(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

  logic                    started;
  ph_t                     phase;
  logic [31:0]             rem;
  logic [4:0]              start;
  logic [10:0]             part;
  logic                    ch_last;

  logic [PH_N-1:0]         en;
  logic [PH_W-1:0]         first_idx;
  logic [PH_W-1:0]         nxt_idx;
  logic                    nxt_found;
  ph_t                     cur;
  ph_t                     ph_next;
  logic                    emit;
  logic                    is_last;

  logic [5:0]              lz;
  logic                    rem_zero;
  logic                    short_run;
  logic [4:0]              lz11;
  logic [31:0]             shifted;
  logic [5:0]              ch_imm;
  logic [10:0]             part_next;
  logic [31:0]             rem_next;

  op_t                     o_kind;
  logic [REG_W-1:0]        o_rd;
  logic [REG_W-1:0]        o_rs1;
  logic [REG_W-1:0]        o_rs2;
  logic signed [IMM_W-1:0] o_imm;

  assign emit = job_valid && (!m_tvalid || m_tready);
  assign pop  = emit && is_last;

  // Pick the current phase and the next enabled one
  always_comb begin
    en            = '0;
    en[PH_G1_LUI] = job.g1_lui;
    en[PH_G1_OP2] = job.g1_op2;
    en[PH_ZX_SLL] = job.zext;
    en[PH_ZX_SRL] = job.zext;
    en[PH_G2_LUI] = job.g2_lui;
    en[PH_G2_OP2] = job.g2_op2;
    en[PH_SLL32]  = job.sll;
    en[PH_ADD]    = job.add;
    en[PH_CH_SLL] = job.chunk;
    en[PH_CH_ORI] = job.chunk;
    first_idx = '0;
    for (int i = PH_N - 1; i >= 0; i--) begin
      if (en[i]) begin
        first_idx = PH_W'(i);
      end
    end
    cur = started ? phase : ph_t'(first_idx);
    nxt_idx   = '0;
    nxt_found = 1'b0;
    for (int i = PH_N - 1; i >= 0; i--) begin
      if (en[i] && (PH_W'(i) > PH_W'(cur))) begin
        nxt_idx   = PH_W'(i);
        nxt_found = 1'b1;
      end
    end
  end

  // Chunk search: next set bit of the remaining lower half
  always_comb begin
    lz        = lead_zeros(rem);
    rem_zero  = (rem == '0);
    short_run = (lz <= 6'd20);
    lz11      = lz[4:0] + 5'd11;
    shifted   = rem << lz[4:0];
    ch_imm    = short_run ? (lz - {1'b0, start} + 6'd11) : (6'd32 - {1'b0, start});
    part_next = short_run ? shifted[31:21] : rem[10:0];
    rem_next  = rem & (32'hFFFF_FFFF >> lz11);
  end

  // Decode the current phase into one instruction
  always_comb begin
    o_kind  = OP_ADD;
    o_rd    = job.rd;
    o_rs1   = job.rd;
    o_rs2   = REG_X0;
    o_imm   = '0;
    is_last = !nxt_found;
    ph_next = ph_t'(nxt_idx);
    unique case (cur)
      PH_G1_LUI: begin
        o_kind = OP_LUI;
        o_rs1  = REG_X0;
        o_imm  = job.g1_lui_imm;
      end
      PH_G1_OP2: begin
        o_kind = job.g1_op2_kind;
        o_rs1  = job.g1_op2_rs1;
        o_imm  = job.g1_op2_imm;
      end
      PH_ZX_SLL: begin
        o_kind = OP_SLLI;
        o_imm  = IMM_W'(32);
      end
      PH_ZX_SRL: begin
        o_kind = OP_SRLI;
        o_imm  = IMM_W'(32);
      end
      PH_G2_LUI: begin
        o_kind = OP_LUI;
        o_rd   = job.r2;
        o_rs1  = REG_X0;
        o_imm  = job.g2_lui_imm;
      end
      PH_G2_OP2: begin
        o_kind = job.g2_op2_kind;
        o_rd   = job.r2;
        o_rs1  = job.g2_op2_rs1;
        o_imm  = job.g2_op2_imm;
      end
      PH_SLL32: begin
        o_kind = OP_SLLI;
        o_rd   = job.r2;
        o_rs1  = job.r2;
        o_imm  = IMM_W'(32);
      end
      PH_ADD: begin
        o_kind = OP_ADD;
        o_rs2  = job.r2;
      end
      PH_CH_SLL: begin
        o_kind  = OP_SLLI;
        o_imm   = {{(IMM_W-6){1'b0}}, rem_zero ? (6'd32 - {1'b0, start}) : ch_imm};
        is_last = rem_zero;
        ph_next = PH_CH_ORI;
      end
      PH_CH_ORI: begin
        o_kind  = OP_ORI;
        o_imm   = {{(IMM_W-11){1'b0}}, part};
        is_last = ch_last;
        ph_next = PH_CH_SLL;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  // Hold sequencer control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      phase    <= PH_G1_LUI;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        started  <= !is_last;
        phase    <= ph_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Load the output register and the chunk state
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {{(OUT_DATA_W-IMM_W-3*REG_W){1'b0}}, o_imm, o_rs2, o_rs1, o_rd};
      m_tuser <= o_kind;
      m_tlast <= is_last;
      if (cur == PH_CH_SLL) begin
        part    <= part_next;
        ch_last <= !short_run;
        rem     <= rem_next;
        start   <= lz11;
      end else if (cur != PH_CH_ORI) begin
        rem   <= job.low;
        start <= '0;
      end
    end
  end

endmodule

// File: sv/load_immediate_sequence_expander_top.sv
// ----------------------------------------------------------------------------
// load_immediate_sequence_expander_top: 64-bit load-immediate expander
// Turns each immediate into its lui/addi/ori/slli/srli/add sequence, one
// instruction per output transfer, with tlast on the final instruction.
//
//   channel | dir | tdata (low bit up)                          | tuser        | tlast
//   s_      | in  | immediate, dest_reg, scratch_reg (80 bits)  | scratch_free | -
//   m_      | out | rd_out, rs1_out, rs2_out, imm_out (40 bits) | op_kind      | last
//
// The back sequencer issues one instruction per cycle while a job waits in the
// queue and the output register is empty or m_tready is high.
// The front takes a new item each cycle while the two-entry job queue has room.
// Reset (rst, synchronous) empties the queue, idles the sequencer and drops m_tvalid.
// With m_tready low the output register holds; the queue fills, then s_tready falls.
// ----------------------------------------------------------------------------
module load_immediate_sequence_expander_top
  import lise_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // immediate[63:0], dest_reg[68:64], scratch_reg[73:69]
  input  logic [IN_USER_W-1:0]  s_tuser,   // scratch_free[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // rd_out[4:0], rs1_out[9:5], rs2_out[14:10], imm_out[35:15]
  output logic [OUT_USER_W-1:0] m_tuser,   // op_kind[2:0]
  output logic                  m_tlast    // last
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic job_valid;
  job_t job;
  logic pop;

  // Classify incoming immediates
  lise_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decouple front from back
  lise_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop        (pop),
    .pop_job    (job)
  );

  // Issue instructions
  lise_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: tb/tb_load_immediate_sequence_expander_top.sv
// ----------------------------------------------------------------------------
// tb_load_immediate_sequence_expander_top: self-checking bench for the expander
// Each immediate accepted on the input stream is expanded by a model in the
// bench into the expected instruction sequence. Every output transfer is
// compared field by field against the oldest expected instruction. A directed
// set of corner values comes first, then three random phases under different
// amounts of source and sink idling, the last one with a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_load_immediate_sequence_expander_top
  import lise_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One emitted instruction as seen on the output stream
  typedef struct packed {
    op_t         kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
    logic        last;
  } instr_t;

  // Expected-sequence store: expands accepted immediates, checks transfers
  class li_expansion_scoreboard;
    instr_t pending_instrs[$];
    instr_t seq[$];
    int     errors = 0;

    task report(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch %s: expected 0x%0h got 0x%0h", what, want, got);
      errors++;
    endtask

    // Append one instruction, at most eight per immediate
    function void add_instr(op_t k, logic [4:0] rd, logic [4:0] rs1,
                            logic [4:0] rs2, logic [63:0] imm);
      instr_t ins;
      if (seq.size() >= 8) return;
      ins.kind = k;
      ins.rd   = rd;
      ins.rs1  = rs1;
      ins.rs2  = rs2;
      ins.imm  = imm[20:0];
      ins.last = 1'b0;
      seq.push_back(ins);
    endfunction

    // Rounded lui plus addi, or a lone ori, for a 32-bit upper value
    function void build_upper(logic [4:0] r, logic [63:0] val);
      logic [63:0] h, l;
      h = $signed(val + 64'h800) >>> 12;
      l = val & 64'hFFF;
      if (h != 0) begin
        add_instr(OP_LUI, r, REG_X0, REG_X0, h & 64'hFFFFF);
        if (l != 0) add_instr(OP_ADDI, r, r, REG_X0, l);
      end else begin
        add_instr(OP_ORI, r, REG_X0, REG_X0, l);
      end
    endfunction

    // Work out the full sequence for one accepted immediate
    function void expand_immediate(logic [63:0] value, logic [4:0] rd,
                                   logic sfree, logic [4:0] sreg);
      logic [63:0] t, hi, lo, up, low, sim, mask, part;
      logic [4:0]  tr;
      bit          have_temp, zext_done;
      int          zeros, i;
      seq.delete();
      t = value + 64'h800;
      if (t + 64'h8000_0000 < 64'h1_0000_0000) begin
        // fits in 32 bits after rounding
        hi = $signed(t) >>> 12;
        lo = {{52{value[11]}}, value[11:0]};
        if (hi != 0) begin
          add_instr(OP_LUI, rd, REG_X0, REG_X0, hi);
          if (lo != 0) add_instr(OP_ADDI, rd, rd, REG_X0, lo);
        end else begin
          add_instr(OP_ADDI, rd, REG_X0, REG_X0, lo);
        end
      end else begin
        up  = $signed(value) >>> 32;
        low = {32'h0, value[31:0]};
        have_temp = 1'b1;
        tr = rd;
        if (up != 0 && low != 0) begin
          if (sfree) tr = sreg;
          else have_temp = 1'b0;
        end
        if (have_temp) begin
          // lower half first, tracking what the register will really hold
          sim = '0;
          zext_done = 1'b0;
          if (low != 0) begin
            hi = (low + 64'h800) >> 12;
            lo = low & 64'hFFF;
            if (hi != 0) begin
              hi = hi & 64'hFFFFF;
              sim = {{32{hi[19]}}, hi[19:0], 12'h000};
              add_instr(OP_LUI, rd, REG_X0, REG_X0, hi);
              if (lo != 0) begin
                sim = sim + {{52{lo[11]}}, lo[11:0]};
                add_instr(OP_ADDI, rd, rd, REG_X0, lo);
              end
            end else begin
              sim = lo;
              add_instr(OP_ORI, rd, REG_X0, REG_X0, lo);
            end
          end
          // compensate for the sign smeared into the upper half
          if (sim[32]) begin
            if (up == 0) begin
              add_instr(OP_SLLI, rd, rd, REG_X0, 32);
              add_instr(OP_SRLI, rd, rd, REG_X0, 32);
              zext_done = 1'b1;
            end else begin
              up = (up - 64'hFFFF_FFFF) & 64'hFFFF_FFFF;
            end
          end
          if (!zext_done && up != 0) begin
            if (low == 0) tr = rd;
            build_upper(tr, up);
            add_instr(OP_SLLI, tr, tr, REG_X0, 32);
            if (low != 0) add_instr(OP_ADD, rd, rd, tr, 0);
          end
        end else begin
          // no scratch: shift the lower half in, up to 11 bits at a time
          build_upper(rd, up);
          mask  = 64'h8000_0000;
          zeros = 0;
          i     = 0;
          while (i < 32) begin
            if ((low & mask) == 0) begin
              mask = mask >> 1;
              zeros++;
              if (i == 31) add_instr(OP_SLLI, rd, rd, REG_X0, zeros);
              i++;
            end else begin
              part = ((low << i) & 64'hFFFF_FFFF) >> i;
              if (i + 11 < 32) begin
                part = part >> (32 - (i + 11));
                add_instr(OP_SLLI, rd, rd, REG_X0, zeros + 11);
                add_instr(OP_ORI, rd, rd, REG_X0, part);
                i    = i + 11;
                mask = mask >> 11;
                zeros = 0;
              end else begin
                add_instr(OP_SLLI, rd, rd, REG_X0, zeros + (32 - i));
                add_instr(OP_ORI, rd, rd, REG_X0, part);
                i = 32;
              end
            end
          end
        end
      end
      seq[seq.size() - 1].last = 1'b1;
      foreach (seq[k]) pending_instrs.push_back(seq[k]);
    endfunction

    // Compare one output transfer against the oldest expectation
    task check_instr(instr_t got);
      instr_t want;
      if (pending_instrs.size() == 0) begin
        report("instruction with none pending", '0, got);
        return;
      end
      want = pending_instrs.pop_front();
      if (got.kind !== want.kind) report("op_kind", want.kind, got.kind);
      if (got.rd   !== want.rd)   report("rd_out", want.rd, got.rd);
      if (got.rs1  !== want.rs1)  report("rs1_out", want.rs1, got.rs1);
      if (got.rs2  !== want.rs2)  report("rs2_out", want.rs2, got.rs2);
      if (got.imm  !== want.imm)  report("imm_out", want.imm, got.imm);
      if (got.last !== want.last) report("last", want.last, got.last);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // immediate, dest_reg, scratch_reg, zero pad
  logic [IN_USER_W-1:0]  s_tuser = '0;   // scratch_free
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // rd_out, rs1_out, rs2_out, imm_out, zero pad
  logic [OUT_USER_W-1:0] m_tuser;        // op_kind
  logic                  m_tlast;

  li_expansion_scoreboard sb = new();

  int src_idle_pct  = 28;
  int sink_idle_pct = 66;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  int hold_left     = 0;

  load_immediate_sequence_expander_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one immediate after a random gap and hold it until the transfer
  task automatic send_item(logic [63:0] value, logic [4:0] rd, logic sfree,
                           logic [4:0] sreg);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, sreg, rd, value};
    s_tuser  <= sfree;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.expand_immediate(value, rd, sfree, sreg);
  endtask

  // Bias towards path boundaries, sparse lower halves and zero halves
  function automatic logic [63:0] random_immediate();
    logic [31:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 7))
      0: return {a, b};
      1: return {{32{b[31]}}, b};
      2: return {32'h0, b};
      3: return {32'hFFFF_FFFF, b};
      4: return {a, b & $urandom & $urandom};
      5: return {{51{b[12]}}, b[12:0]};
      6: return {a, 32'h0};
      default: return {(a[1] ? 32'h0 : a), 32'h7FFF_F000 + {19'h0, b[12:0]}};
    endcase
  endfunction

  task automatic random_items(int count);
    logic [4:0] rd, sreg;
    for (int n = 0; n < count; n++) begin
      rd = 5'($urandom);
      case ($urandom_range(0, 5))
        0: sreg = rd;
        1: sreg = REG_X0;
        default: sreg = 5'($urandom);
      endcase
      send_item(random_immediate(), rd, $urandom_range(0, 9) < 6, sreg);
    end
  endtask

  // Sink: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      instr_t got;
      got.kind = op_t'(m_tuser);
      got.rd   = m_tdata[4:0];
      got.rs1  = m_tdata[9:5];
      got.rs2  = m_tdata[14:10];
      got.imm  = m_tdata[35:15];
      got.last = m_tlast;
      sb.check_instr(got);
    end
    if (hold_off_req && !hold_off_done) begin
      hold_left = 400;
      hold_off_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_item(64'h0, 5'd1, 1'b0, 5'd0);
    send_item(64'h1, 5'd31, 1'b1, 5'd2);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0, 5'd0);
    send_item(64'h7FF, 5'd3, 1'b1, 5'd4);
    send_item(64'h800, 5'd5, 1'b0, 5'd6);
    send_item(64'hFFFF_FFFF_FFFF_F800, 5'd7, 1'b1, 5'd8);
    send_item(64'h0000_0000_7FFF_F7FF, 5'd9, 1'b0, 5'd10);
    send_item(64'hFFFF_FFFF_8000_0000, 5'd11, 1'b1, 5'd12);
    send_item(64'h0000_0000_7FFF_F800, 5'd13, 1'b1, 5'd14);
    send_item(64'h0000_0000_8000_0000, 5'd15, 1'b0, 5'd16);
    send_item(64'h0000_0000_FFFF_FFFF, 5'd17, 1'b1, 5'd18);
    send_item(64'hFFFF_FFFF_7FFF_F7FF, 5'd19, 1'b1, 5'd20);
    send_item(64'hFFFF_FFFF_0000_0000, 5'd21, 1'b0, 5'd22);
    send_item(64'h1234_5678_0000_0000, 5'd23, 1'b1, 5'd24);
    send_item(64'h1234_5678_9ABC_DEF0, 5'd25, 1'b1, 5'd26);
    send_item(64'h1234_5678_9ABC_DEF0, 5'd27, 1'b1, 5'd27);
    send_item(64'h1234_5678_9ABC_DEF0, 5'd28, 1'b1, 5'd0);
    send_item(64'h1234_5678_9ABC_DEF0, 5'd29, 1'b0, 5'd30);
    send_item(64'h1234_5678_8000_0000, 5'd30, 1'b0, 5'd1);
    send_item(64'h0000_0001_0000_0001, 5'd2, 1'b0, 5'd3);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 5'd31, 1'b0, 5'd31);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 5'd4, 1'b1, 5'd31);
    send_item(64'h8000_0000_0000_0000, 5'd6, 1'b1, 5'd5);
    send_item(64'h8000_0000_0000_0001, 5'd8, 1'b0, 5'd9);
    send_item(64'h8000_0000_0000_0001, 5'd10, 1'b1, 5'd11);

    random_items(120);

    // swap the idling between the two sides
    src_idle_pct  = 66;
    sink_idle_pct = 28;
    random_items(120);

    // no idling, with one long sink hold-off to back the block up
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_off_req  = 1'b1;
    random_items(106);
    s_tvalid <= 1'b0;

    // drain and let any stray transfer show up
    while (sb.pending_instrs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
